// ----- sv/tpd_pkg.sv -----
// Shared types, codes and lookup functions for the telemetry packet deframer.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int ZONE_COUNT_DEF = 64;

    localparam logic [7:0] HDR_SIZE = 8'd50;
    localparam logic [7:0] SET_SIZE = 8'd16;
    localparam logic [7:0] MAGIC_0  = 8'h54;  // 'T'
    localparam logic [7:0] MAGIC_1  = 8'h46;  // 'F'
    localparam logic [7:0] GEOM_DIM = 8'd8;

    // packet kinds, in configuration register order
    localparam logic [2:0] KIND_WAKE     = 3'd0;
    localparam logic [2:0] KIND_FRAME    = 3'd1;
    localparam logic [2:0] KIND_STATUS   = 3'd2;
    localparam logic [2:0] KIND_SLEEPING = 3'd3;
    localparam logic [2:0] KIND_SET      = 3'd4;
    localparam logic [2:0] KIND_ACK      = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_VERSION  = 3'd0;
    localparam logic [2:0] REG_WAKE     = 3'd1;
    localparam logic [2:0] REG_FRAME    = 3'd2;
    localparam logic [2:0] REG_STATUS   = 3'd3;
    localparam logic [2:0] REG_SLEEPING = 3'd4;
    localparam logic [2:0] REG_SET      = 3'd5;
    localparam logic [2:0] REG_ACK      = 3'd6;

    // verdict codes
    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_HEADER   = 3'd1;
    localparam logic [2:0] VERDICT_LENGTH   = 3'd2;
    localparam logic [2:0] VERDICT_CRC      = 3'd3;
    localparam logic [2:0] VERDICT_BOUNDS   = 3'd4;
    localparam logic [2:0] VERDICT_GEOMETRY = 3'd5;

    // field tags
    localparam logic [4:0] TAG_FRAMING  = 5'd0;
    localparam logic [4:0] TAG_VERSION  = 5'd1;
    localparam logic [4:0] TAG_TYPE     = 5'd2;
    localparam logic [4:0] TAG_NODE     = 5'd3;
    localparam logic [4:0] TAG_ROWS     = 5'd4;
    localparam logic [4:0] TAG_COLS     = 5'd5;
    localparam logic [4:0] TAG_STATUS   = 5'd6;
    localparam logic [4:0] TAG_SEQ      = 5'd7;
    localparam logic [4:0] TAG_CFG_REV  = 5'd8;
    localparam logic [4:0] TAG_SLEEP_S  = 5'd9;
    localparam logic [4:0] TAG_WAKE_S   = 5'd10;
    localparam logic [4:0] TAG_MEASURE  = 5'd11;
    localparam logic [4:0] TAG_RETRY    = 5'd12;
    localparam logic [4:0] TAG_AWAKE_MS = 5'd13;
    localparam logic [4:0] TAG_LSLEEP   = 5'd14;
    localparam logic [4:0] TAG_TAWAKE   = 5'd15;
    localparam logic [4:0] TAG_TSLEEP   = 5'd16;
    localparam logic [4:0] TAG_WAKE_CNT = 5'd17;
    localparam logic [4:0] TAG_BATTERY  = 5'd18;
    localparam logic [4:0] TAG_MASK     = 5'd19;
    localparam logic [4:0] TAG_DIST     = 5'd20;
    localparam logic [4:0] TAG_PAYLOAD  = 5'd21;
    localparam logic [4:0] TAG_CRC      = 5'd22;

    typedef struct packed {
        logic [4:0] tag;
        logic [2:0] idx;
        logic [5:0] zone;
    } field_info_t;

    function automatic logic [7:0] size_of_kind(input logic [2:0] kind,
                                                input logic [7:0] frame_size);
        logic [7:0] s;
        unique case (kind)
            KIND_WAKE:     s = 8'd52;
            KIND_FRAME:    s = frame_size;
            KIND_STATUS:   s = 8'd52;
            KIND_SLEEPING: s = 8'd56;
            KIND_SET:      s = SET_SIZE;
            KIND_ACK:      s = 8'd53;
            default:       s = 8'd0;
        endcase
        return s;
    endfunction

    // uplink header layout, offsets 0..49
    function automatic field_info_t uplink_lookup(input logic [7:0] off);
        field_info_t f;
        f = '0;
        unique case (off) inside
            [8'd0:8'd1]:   begin f.tag = TAG_FRAMING;  f.idx = off[2:0];          end
            8'd2:          f.tag = TAG_VERSION;
            8'd3:          f.tag = TAG_TYPE;
            8'd4:          f.tag = TAG_NODE;
            8'd5:          f.tag = TAG_ROWS;
            8'd6:          f.tag = TAG_COLS;
            8'd7:          f.tag = TAG_STATUS;
            [8'd8:8'd11]:  begin f.tag = TAG_SEQ;      f.idx = 3'(off - 8'd8);  end
            [8'd12:8'd13]: begin f.tag = TAG_CFG_REV;  f.idx = 3'(off - 8'd12); end
            [8'd14:8'd15]: begin f.tag = TAG_SLEEP_S;  f.idx = 3'(off - 8'd14); end
            [8'd16:8'd17]: begin f.tag = TAG_WAKE_S;   f.idx = 3'(off - 8'd16); end
            8'd18:         f.tag = TAG_MEASURE;
            8'd19:         f.tag = TAG_RETRY;
            [8'd20:8'd23]: begin f.tag = TAG_AWAKE_MS; f.idx = 3'(off - 8'd20); end
            [8'd24:8'd27]: begin f.tag = TAG_LSLEEP;   f.idx = 3'(off - 8'd24); end
            [8'd28:8'd35]: begin f.tag = TAG_TAWAKE;   f.idx = 3'(off - 8'd28); end
            [8'd36:8'd43]: begin f.tag = TAG_TSLEEP;   f.idx = 3'(off - 8'd36); end
            [8'd44:8'd47]: begin f.tag = TAG_WAKE_CNT; f.idx = 3'(off - 8'd44); end
            [8'd48:8'd49]: begin f.tag = TAG_BATTERY;  f.idx = 3'(off - 8'd48); end
            default:       f = '0;
        endcase
        return f;
    endfunction

    // downlink config-set layout; offsets 5 and 13 fall through to framing
    function automatic field_info_t set_lookup(input logic [7:0] off);
        field_info_t f;
        f = '0;
        unique case (off) inside
            [8'd0:8'd1]:   begin f.tag = TAG_FRAMING; f.idx = off[2:0];          end
            8'd2:          f.tag = TAG_VERSION;
            8'd3:          f.tag = TAG_TYPE;
            8'd4:          f.tag = TAG_NODE;
            [8'd6:8'd7]:   begin f.tag = TAG_CFG_REV; f.idx = 3'(off - 8'd6);  end
            [8'd8:8'd9]:   begin f.tag = TAG_SLEEP_S; f.idx = 3'(off - 8'd8);  end
            [8'd10:8'd11]: begin f.tag = TAG_WAKE_S;  f.idx = 3'(off - 8'd10); end
            8'd12:         f.tag = TAG_MEASURE;
            default:       f = '0;
        endcase
        return f;
    endfunction

endpackage

// ----- sv/tpd_if.sv -----
// Valid/ready channel interfaces for received bytes and per-byte results.
`timescale 1ns / 1ps

interface tpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;

    modport source (output valid, input ready, output rx_byte, output end_of_packet);
    modport sink   (input valid, output ready, input rx_byte, input end_of_packet);
endinterface

interface tpd_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] field_tag;
    logic [2:0] field_byte_index;
    logic [5:0] zone_index;
    logic [7:0] byte_out;
    logic       packet_done;
    logic [2:0] verdict;
    logic [2:0] packet_kind;

    modport source (output valid, input ready, output field_tag, output field_byte_index,
                    output zone_index, output byte_out, output packet_done,
                    output verdict, output packet_kind);
    modport sink   (input valid, output ready, input field_tag, input field_byte_index,
                    input zone_index, input byte_out, input packet_done,
                    input verdict, input packet_kind);
endinterface

// ----- sv/tpd_crc_step.sv -----
// CRC-16/CCITT-FALSE update over one byte, MSB first.
`timescale 1ns / 1ps

module tpd_crc_step (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    localparam logic [15:0] POLY = 16'h1021;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ POLY) : {c[14:0], 1'b0};
        end
        crc_out = c;
    end
endmodule

// ----- sv/tpd_field_map.sv -----
// Maps a packet kind and byte offset to field tag, byte index and zone.
`timescale 1ns / 1ps

module tpd_field_map #(
    parameter int ZONE_COUNT = tpd_pkg::ZONE_COUNT_DEF
) (
    input  logic [2:0]          kind,
    input  logic [7:0]          off,
    output tpd_pkg::field_info_t info
);
    import tpd_pkg::*;

    localparam logic [7:0] FRAME_SIZE = 8'(60 + 2 * ZONE_COUNT);

    logic [7:0] size;
    logic [7:0] rel_hdr;
    logic [7:0] rel_dist;
    logic [7:0] rel_crc;
    logic       in_crc;

    assign size     = size_of_kind(kind, FRAME_SIZE);
    assign rel_hdr  = off - HDR_SIZE;
    assign rel_dist = off - (HDR_SIZE + 8'd8);
    assign rel_crc  = off + 8'd2 - size;
    assign in_crc   = (size != 8'd0) && (({1'b0, off} + 9'd2) >= {1'b0, size})
                      && (off < size);

    always_comb
    begin
        info = '0;
        priority if (in_crc)
        begin
            info.tag = TAG_CRC;
            info.idx = rel_crc[2:0];
        end
        else if (kind == KIND_SET)
        begin
            info = set_lookup(off);
        end
        else if (off < HDR_SIZE)
        begin
            info = uplink_lookup(off);
        end
        else if (size != 8'd0 && off < size)
        begin
            if (kind == KIND_FRAME)
            begin
                if (off < HDR_SIZE + 8'd8)
                begin
                    info.tag = TAG_MASK;
                    info.idx = rel_hdr[2:0];
                end
                else
                begin
                    info.tag  = TAG_DIST;
                    info.idx  = {2'b00, rel_dist[0]};
                    info.zone = rel_dist[6:1];
                end
            end
            else if (kind == KIND_SLEEPING || kind == KIND_ACK)
            begin
                info.tag = TAG_PAYLOAD;
                info.idx = rel_hdr[2:0];
            end
        end
        else
        begin
            // past the layout or unknown kind: framing
            info = '0;
        end
    end
endmodule

// ----- sv/telemetry_packet_deframer.sv -----
// Top level: byte-wise packet deframer with CRC check and end-of-packet verdict.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   rx_byte[7:0], end_of_packet
//   out_ch   out  valid/ready   field_tag, field_byte_index, zone_index, byte_out,
//                               packet_done, verdict, packet_kind
//   cfg      in   cfg_we        cfg_index[2:0], cfg_wdata[7:0]
//
// One byte per cycle while out_ch is ready; a byte passes the input, then the result register.
// The input register feeds the CRC step, field map and checks; the result register
// holds the answer. Per-packet state advances as a byte moves to the result register.
// Reset clears per-packet state and loads the register defaults; no init sweep.
// A stalled output holds one result and one waiting byte before in_ch.ready drops.
`timescale 1ns / 1ps

module telemetry_packet_deframer #(
    parameter int ZONE_COUNT = tpd_pkg::ZONE_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    tpd_in_if.sink     in_ch,
    tpd_out_if.source  out_ch
);
    import tpd_pkg::*;

    localparam logic [7:0] FRAME_SIZE = 8'(60 + 2 * ZONE_COUNT);

    // configuration
    logic [7:0] version_reg, wake_code_reg, frame_code_reg, status_code_reg;
    logic [7:0] sleeping_code_reg, set_code_reg, ack_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg       <= 8'd1;
            wake_code_reg     <= 8'd0;
            frame_code_reg    <= 8'd1;
            status_code_reg   <= 8'd2;
            sleeping_code_reg <= 8'd3;
            set_code_reg      <= 8'd4;
            ack_code_reg      <= 8'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERSION:  version_reg       <= cfg_wdata;
                REG_WAKE:     wake_code_reg     <= cfg_wdata;
                REG_FRAME:    frame_code_reg    <= cfg_wdata;
                REG_STATUS:   status_code_reg   <= cfg_wdata;
                REG_SLEEPING: sleeping_code_reg <= cfg_wdata;
                REG_SET:      set_code_reg      <= cfg_wdata;
                REG_ACK:      ack_code_reg      <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eop_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.rx_byte;
            in_eop_reg  <= in_ch.end_of_packet;
        end
    end

    // per-packet state
    logic [7:0]  byte_count_reg;
    logic [15:0] crc_running_reg, crc_one_back_reg;
    logic [7:0]  prev_byte_reg;
    logic        header_bad_reg, geometry_bad_reg;
    logic [2:0]  kind_seen_reg;
    logic [15:0] sleep_s_reg, wake_s_reg;
    logic [7:0]  measure_reg;

    logic [7:0]  off, b;
    logic [2:0]  kind_match, kind_next;
    logic        header_bad_next, geometry_bad_next;
    logic [15:0] sleep_s_next, wake_s_next;
    logic [7:0]  measure_next, count_next;
    logic [15:0] crc_next;
    logic [2:0]  verdict_next;
    field_info_t info;

    assign off = byte_count_reg;
    assign b   = in_byte_reg;

    tpd_crc_step u_crc (
        .crc_in  (crc_running_reg),
        .data    (b),
        .crc_out (crc_next)
    );

    always_comb
    begin
        priority if (b == wake_code_reg)     kind_match = KIND_WAKE;
        else if (b == frame_code_reg)        kind_match = KIND_FRAME;
        else if (b == status_code_reg)       kind_match = KIND_STATUS;
        else if (b == sleeping_code_reg)     kind_match = KIND_SLEEPING;
        else if (b == set_code_reg)          kind_match = KIND_SET;
        else if (b == ack_code_reg)          kind_match = KIND_ACK;
        else                                 kind_match = KIND_UNKNOWN;
    end

    always_comb
    begin
        kind_next = (off == 8'd3) ? kind_match : kind_seen_reg;
        header_bad_next = header_bad_reg
                          || (off == 8'd0 && b != MAGIC_0)
                          || (off == 8'd1 && b != MAGIC_1)
                          || (off == 8'd2 && b != version_reg);
        geometry_bad_next = geometry_bad_reg || ((off == 8'd5 || off == 8'd6) && b != GEOM_DIM);
        sleep_s_next = sleep_s_reg;
        wake_s_next  = wake_s_reg;
        measure_next = measure_reg;
        if (kind_next == KIND_SET)
        begin
            if (off == 8'd8)  sleep_s_next = {sleep_s_reg[15:8], b};
            if (off == 8'd9)  sleep_s_next = {b, sleep_s_reg[7:0]};
            if (off == 8'd10) wake_s_next  = {wake_s_reg[15:8], b};
            if (off == 8'd11) wake_s_next  = {b, wake_s_reg[7:0]};
            if (off == 8'd12) measure_next = b;
        end
        count_next = (off == 8'hFF) ? off : off + 8'd1;
    end

    tpd_field_map #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_map (
        .kind (kind_next),
        .off  (off),
        .info (info)
    );

    // stored CRC is compared against the CRC over all bytes before it
    always_comb
    begin
        verdict_next = VERDICT_OK;
        if (in_eop_reg)
        begin
            priority if (count_next < SET_SIZE || header_bad_next)
                verdict_next = VERDICT_HEADER;
            else if (kind_next == KIND_UNKNOWN
                     || count_next != size_of_kind(kind_next, FRAME_SIZE))
                verdict_next = VERDICT_LENGTH;
            else if ({b, prev_byte_reg} != crc_one_back_reg)
                verdict_next = VERDICT_CRC;
            else if (kind_next == KIND_SET
                     && (sleep_s_next > 16'd3600 || wake_s_next < 16'd1
                         || wake_s_next > 16'd3600 || measure_next < 8'd1
                         || measure_next > 8'd10))
                verdict_next = VERDICT_BOUNDS;
            else if (kind_next == KIND_FRAME && geometry_bad_next)
                verdict_next = VERDICT_GEOMETRY;
            else
                verdict_next = VERDICT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= 8'd0;
            crc_running_reg  <= 16'hFFFF;
            crc_one_back_reg <= 16'hFFFF;
            prev_byte_reg    <= 8'd0;
            header_bad_reg   <= 1'b0;
            geometry_bad_reg <= 1'b0;
            kind_seen_reg    <= KIND_UNKNOWN;
            sleep_s_reg      <= 16'd0;
            wake_s_reg       <= 16'd0;
            measure_reg      <= 8'd0;
        end
        else if (advance)
        begin
            if (in_eop_reg)
            begin
                byte_count_reg   <= 8'd0;
                crc_running_reg  <= 16'hFFFF;
                crc_one_back_reg <= 16'hFFFF;
                prev_byte_reg    <= 8'd0;
                header_bad_reg   <= 1'b0;
                geometry_bad_reg <= 1'b0;
                kind_seen_reg    <= KIND_UNKNOWN;
                sleep_s_reg      <= 16'd0;
                wake_s_reg       <= 16'd0;
                measure_reg      <= 8'd0;
            end
            else
            begin
                byte_count_reg   <= count_next;
                crc_running_reg  <= crc_next;
                crc_one_back_reg <= crc_running_reg;
                prev_byte_reg    <= b;
                header_bad_reg   <= header_bad_next;
                geometry_bad_reg <= geometry_bad_next;
                kind_seen_reg    <= kind_next;
                sleep_s_reg      <= sleep_s_next;
                wake_s_reg       <= wake_s_next;
                measure_reg      <= measure_next;
            end
        end
    end

    // result register
    logic [4:0] tag_reg;
    logic [2:0] idx_reg;
    logic [5:0] zone_reg;
    logic [7:0] byte_reg;
    logic       done_reg;
    logic [2:0] verdict_reg;
    logic [2:0] kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_reg     <= info.tag;
            idx_reg     <= info.idx;
            zone_reg    <= info.zone;
            byte_reg    <= b;
            done_reg    <= in_eop_reg;
            verdict_reg <= verdict_next;
            kind_reg    <= kind_next;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.field_tag        = tag_reg;
    assign out_ch.field_byte_index = idx_reg;
    assign out_ch.zone_index       = zone_reg;
    assign out_ch.byte_out         = byte_reg;
    assign out_ch.packet_done      = done_reg;
    assign out_ch.verdict          = verdict_reg;
    assign out_ch.packet_kind      = kind_reg;

    // checks
    a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> verdict_reg == VERDICT_OK)
        else $error("verdict set on a byte that is not the last");

    a_ok_needs_known_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg && verdict_reg == VERDICT_OK |-> kind_reg != KIND_UNKNOWN)
        else $error("good packet with unknown kind");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_eop_reg |=> byte_count_reg == 8'd0 && kind_seen_reg == KIND_UNKNOWN)
        else $error("packet state not cleared after last byte");

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input taken while both stages are full and stalled");
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the telemetry packet deframer: byte stream in, per-byte results out.
`timescale 1ns / 1ps

module testbench;
    import tpd_pkg::*;

    localparam int ZONES       = tpd_pkg::ZONE_COUNT_DEF;
    localparam int FRAME_BYTES = 60 + 2 * ZONES;
    localparam int WAKE_BYTES  = 52;
    localparam int STAT_BYTES  = 52;
    localparam int SLEEP_BYTES = 56;
    localparam int ACK_BYTES   = 53;
    localparam int LONG_BYTES  = 260;
    localparam int DIST_START  = 58;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [4:0] tag;
        logic [2:0] idx;
        logic [5:0] zone;
        logic [7:0] data;
        logic       done;
        logic [2:0] verdict;
        logic [2:0] kind;
    } byte_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_wdata;

    tpd_in_if  in_ch ();
    tpd_out_if out_ch ();

    telemetry_packet_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor copy of registers and per-packet state
    logic [7:0]  reg_val [7];
    logic [7:0]  pk_count;
    logic [15:0] crc_now, crc_back1, crc_back2;
    logic [7:0]  last_seen_byte;
    bit          hdr_bad, geom_bad;
    logic [2:0]  kind_now;
    logic [15:0] set_sleep, set_wake;
    logic [7:0]  set_measure;

    byte_result_t expected_results [$];
    logic [7:0]   pkt [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    int mismatch_count;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic logic [2:0] kind_of_type(input logic [7:0] t);
        if (t == reg_val[REG_WAKE])     return KIND_WAKE;
        if (t == reg_val[REG_FRAME])    return KIND_FRAME;
        if (t == reg_val[REG_STATUS])   return KIND_STATUS;
        if (t == reg_val[REG_SLEEPING]) return KIND_SLEEPING;
        if (t == reg_val[REG_SET])      return KIND_SET;
        if (t == reg_val[REG_ACK])      return KIND_ACK;
        return KIND_UNKNOWN;
    endfunction

    function automatic int packet_size(input logic [2:0] kind);
        case (kind)
            KIND_WAKE:     return WAKE_BYTES;
            KIND_FRAME:    return FRAME_BYTES;
            KIND_STATUS:   return STAT_BYTES;
            KIND_SLEEPING: return SLEEP_BYTES;
            KIND_SET:      return SET_SIZE;
            KIND_ACK:      return ACK_BYTES;
            default:       return 0;
        endcase
    endfunction

    // uplink header map; single-byte fields start at their own offset
    function automatic void uplink_field(input int off, output logic [4:0] tag, output int idx);
        int start;
        start = off;
        tag = TAG_FRAMING;
        if (off < 2)       start = 0;
        else if (off < 3)  tag = TAG_VERSION;
        else if (off < 4)  tag = TAG_TYPE;
        else if (off < 5)  tag = TAG_NODE;
        else if (off < 6)  tag = TAG_ROWS;
        else if (off < 7)  tag = TAG_COLS;
        else if (off < 8)  tag = TAG_STATUS;
        else if (off < 12) begin tag = TAG_SEQ;      start = 8;  end
        else if (off < 14) begin tag = TAG_CFG_REV;  start = 12; end
        else if (off < 16) begin tag = TAG_SLEEP_S;  start = 14; end
        else if (off < 18) begin tag = TAG_WAKE_S;   start = 16; end
        else if (off < 19) tag = TAG_MEASURE;
        else if (off < 20) tag = TAG_RETRY;
        else if (off < 24) begin tag = TAG_AWAKE_MS; start = 20; end
        else if (off < 28) begin tag = TAG_LSLEEP;   start = 24; end
        else if (off < 36) begin tag = TAG_TAWAKE;   start = 28; end
        else if (off < 44) begin tag = TAG_TSLEEP;   start = 36; end
        else if (off < 48) begin tag = TAG_WAKE_CNT; start = 44; end
        else if (off < 50) begin tag = TAG_BATTERY;  start = 48; end
        idx = off - start;
    endfunction

    // config-set map; offsets 5 and 13 stay framing
    function automatic void set_field(input int off, output logic [4:0] tag, output int idx);
        int start;
        start = off;
        tag = TAG_FRAMING;
        if (off < 2)       start = 0;
        else if (off < 3)  tag = TAG_VERSION;
        else if (off < 4)  tag = TAG_TYPE;
        else if (off < 5)  tag = TAG_NODE;
        else if (off < 6)  tag = TAG_FRAMING;
        else if (off < 8)  begin tag = TAG_CFG_REV; start = 6;  end
        else if (off < 10) begin tag = TAG_SLEEP_S; start = 8;  end
        else if (off < 12) begin tag = TAG_WAKE_S;  start = 10; end
        else if (off < 13) tag = TAG_MEASURE;
        idx = off - start;
    endfunction

    function automatic void clear_packet_state();
        pk_count = '0;
        crc_now = 16'hFFFF;
        crc_back1 = 16'hFFFF;
        crc_back2 = 16'hFFFF;
        last_seen_byte = '0;
        hdr_bad = 1'b0;
        kind_now = KIND_UNKNOWN;
        geom_bad = 1'b0;
        set_sleep = '0;
        set_wake = '0;
        set_measure = '0;
    endfunction

    function automatic byte_result_t predict_byte(input logic [7:0] b, input bit last);
        byte_result_t r;
        int off, size, idx, zone, length;
        logic [4:0] tag;
        logic [15:0] stored;
        off = pk_count;
        if (off == 0 && b != MAGIC_0) hdr_bad = 1'b1;
        if (off == 1 && b != MAGIC_1) hdr_bad = 1'b1;
        if (off == 2 && b != reg_val[REG_VERSION]) hdr_bad = 1'b1;
        if (off == 3) kind_now = kind_of_type(b);
        if ((off == 5 || off == 6) && b != GEOM_DIM) geom_bad = 1'b1;
        if (kind_now == KIND_SET)
        begin
            if (off == 8)  set_sleep[7:0] = b;
            if (off == 9)  set_sleep[15:8] = b;
            if (off == 10) set_wake[7:0] = b;
            if (off == 11) set_wake[15:8] = b;
            if (off == 12) set_measure = b;
        end
        size = packet_size(kind_now);
        tag = TAG_FRAMING;
        idx = 0;
        zone = 0;
        if (size != 0 && off + 2 >= size && off < size)
        begin
            tag = TAG_CRC;
            idx = off + 2 - size;
        end
        else if (kind_now == KIND_SET)
            set_field(off, tag, idx);
        else if (off < HDR_SIZE)
            uplink_field(off, tag, idx);
        else if (size != 0 && off < size)
        begin
            if (kind_now == KIND_FRAME)
            begin
                if (off < DIST_START)
                begin
                    tag = TAG_MASK;
                    idx = off - HDR_SIZE;
                end
                else
                begin
                    tag = TAG_DIST;
                    idx = (off - DIST_START) & 1;
                    zone = ((off - DIST_START) >> 1) & 63;
                end
            end
            else if (kind_now == KIND_SLEEPING || kind_now == KIND_ACK)
            begin
                tag = TAG_PAYLOAD;
                idx = (off - HDR_SIZE) & 7;
            end
        end

        crc_back2 = crc_back1;
        crc_back1 = crc_now;
        crc_now = crc16_step(crc_now, b);
        if (pk_count != 8'hFF) pk_count++;

        r.tag = tag;
        r.idx = 3'(idx);
        r.zone = 6'(zone);
        r.data = b;
        r.done = last;
        r.kind = kind_now;
        r.verdict = VERDICT_OK;
        if (last)
        begin
            length = pk_count;
            stored = {b, last_seen_byte};
            if (length < SET_SIZE || hdr_bad)
                r.verdict = VERDICT_HEADER;
            else if (kind_now == KIND_UNKNOWN || length != size)
                r.verdict = VERDICT_LENGTH;
            else if (stored != crc_back2)
                r.verdict = VERDICT_CRC;
            else if (kind_now == KIND_SET && (set_sleep > 3600 || set_wake < 1 ||
                     set_wake > 3600 || set_measure < 1 || set_measure > 10))
                r.verdict = VERDICT_BOUNDS;
            else if (kind_now == KIND_FRAME && geom_bad)
                r.verdict = VERDICT_GEOMETRY;
            clear_packet_state();
        end
        else
            last_seen_byte = b;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        byte_result_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.tag = out_ch.field_tag;
            got.idx = out_ch.field_byte_index;
            got.zone = out_ch.zone_index;
            got.data = out_ch.byte_out;
            got.done = out_ch.packet_done;
            got.verdict = out_ch.verdict;
            got.kind = out_ch.packet_kind;
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected result: byte=%02h tag=%0d", got.data, got.tag);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                        $display({"mismatch: exp tag=%0d idx=%0d zone=%0d byte=%02h done=%0d ",
                                  "verdict=%0d kind=%0d | got tag=%0d idx=%0d zone=%0d ",
                                  "byte=%02h done=%0d verdict=%0d kind=%0d"},
                                 want.tag, want.idx, want.zone, want.data, want.done,
                                 want.verdict, want.kind, got.tag, got.idx, got.zone,
                                 got.data, got.done, got.verdict, got.kind);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.rx_byte = b;
        in_ch.end_of_packet = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(predict_byte(b, last));
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        reg_val[index] = value;
    endtask

    function automatic void seal_packet();
        logic [15:0] crc;
        crc = 16'hFFFF;
        foreach (pkt[i])
            crc = crc16_step(crc, pkt[i]);
        pkt.push_back(crc[7:0]);
        pkt.push_back(crc[15:8]);
    endfunction

    // mostly inside [lo, hi], sometimes just past either end
    function automatic int near_range(input int lo, input int hi, input int maxv);
        int r;
        r = $urandom_range(11);
        if (r < 7)  return $urandom_range(hi, lo);
        if (r == 7) return lo;
        if (r == 8) return hi;
        if (r == 9) return (lo > 0) ? lo - 1 : maxv;
        if (r == 10) return hi + 1;
        return $urandom_range(maxv);
    endfunction

    function automatic void build_body(input int want_kind);
        logic [7:0] t;
        logic [2:0] k;
        int size, s, w, m;
        t = reg_val[int'(REG_WAKE) + want_kind];
        k = kind_of_type(t);
        size = packet_size(k);
        pkt.delete();
        for (int i = 0; i < size - 2; i++)
            pkt.push_back(8'($urandom_range(255)));
        pkt[0] = MAGIC_0;
        pkt[1] = MAGIC_1;
        pkt[2] = reg_val[REG_VERSION];
        pkt[3] = t;
        if (k == KIND_SET)
        begin
            s = near_range(0, 3600, 65535);
            w = near_range(1, 3600, 65535);
            m = near_range(1, 10, 255);
            pkt[8] = s[7:0];
            pkt[9] = s[15:8];
            pkt[10] = w[7:0];
            pkt[11] = w[15:8];
            pkt[12] = m[7:0];
        end
        else if ($urandom_range(99) < 85)
        begin
            pkt[5] = GEOM_DIM;
            pkt[6] = GEOM_DIM;
        end
    endfunction

    function automatic void make_packet();
        int pick, k, n;
        logic [7:0] v;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            // noise: short random burst, sometimes with a plausible start
            n = $urandom_range(20, 1);
            pkt.delete();
            repeat (n) pkt.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                pkt[0] = MAGIC_0;
            return;
        end
        if (pick < 55)      k = KIND_SET;
        else if (pick < 60) k = KIND_FRAME;
        else
        begin
            case ($urandom_range(3))
                0: k = KIND_WAKE;
                1: k = KIND_STATUS;
                2: k = KIND_SLEEPING;
                default: k = KIND_ACK;
            endcase
        end
        build_body(k);
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(3))
                0: pkt[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
                1: pkt[2] ^= 8'($urandom_range(255, 1));
                2:
                begin
                    do
                        v = 8'($urandom_range(255));
                    while (kind_of_type(v) != KIND_UNKNOWN);
                    pkt[3] = v;
                end
                default:
                begin
                    v = 8'($urandom_range(255));
                    if (v == GEOM_DIM) v = '0;
                    pkt[5 + $urandom_range(1)] = v;
                end
            endcase
        end
        seal_packet();
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(2))
                0: pkt[pkt.size() - 1 - $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
                1:
                begin
                    n = $urandom_range(8, 1);
                    repeat (n) void'(pkt.pop_back());
                end
                default:
                begin
                    n = $urandom_range(6, 1);
                    repeat (n) pkt.push_back(8'($urandom_range(255)));
                end
            endcase
        end
    endfunction

    task automatic test_random_traffic(input int item_budget);
        int sent;
        sent = 0;
        while (sent < item_budget)
        begin
            make_packet();
            send_packet();
            sent += pkt.size();
        end
        wait_for_results();
    endtask

    task automatic test_short_packets();
        pkt = '{8'hFF};
        send_packet();
        pkt = '{MAGIC_0, MAGIC_1, 8'h00};
        send_packet();
        wait_for_results();
    endtask

    // in-bounds set packet with every field at its upper edge
    task automatic test_good_config_set();
        pkt = '{MAGIC_0, MAGIC_1, reg_val[REG_VERSION], reg_val[REG_SET], 8'hFF, 8'h00,
                8'hFF, 8'h00, 8'h10, 8'h0E, 8'h10, 8'h0E, 8'd10, 8'hFF};
        seal_packet();
        send_packet();
        wait_for_results();
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 200;
        repeat (2)
        begin
            build_body(KIND_SET);
            seal_packet();
            send_packet();
        end
        wait_for_results();
    endtask

    // byte counter saturation and bytes past the layout
    task automatic test_long_packet();
        build_body(KIND_WAKE);
        while (pkt.size() < LONG_BYTES)
            pkt.push_back(8'($urandom_range(255)));
        send_packet();
        wait_for_results();
    endtask

    task automatic test_extreme_codes();
        write_reg(REG_VERSION, 8'h00);
        write_reg(REG_WAKE, 8'hFF);
        write_reg(REG_FRAME, 8'h80);
        write_reg(REG_STATUS, 8'h7F);
        write_reg(REG_SLEEPING, 8'h01);
        write_reg(REG_SET, 8'hFE);
        write_reg(REG_ACK, 8'h55);
        send_idle_pct = 65;
        recv_stall_pct = 0;
        test_random_traffic(110);
    endtask

    // equal codes: first register in list order claims the type byte
    task automatic test_duplicate_codes();
        write_reg(REG_VERSION, 8'hFF);
        write_reg(REG_WAKE, 8'hA5);
        write_reg(REG_FRAME, 8'hA5);
        write_reg(REG_STATUS, 8'h3C);
        write_reg(REG_SLEEPING, 8'hC3);
        write_reg(REG_SET, 8'h3C);
        write_reg(REG_ACK, 8'hC3);
        send_idle_pct = 0;
        recv_stall_pct = 65;
        test_random_traffic(90);
    endtask

    task automatic test_random_codes();
        write_reg(REG_VERSION, 8'($urandom_range(255)));
        for (int i = int'(REG_WAKE); i <= int'(REG_ACK); i++)
            write_reg(3'(i), 8'($urandom_range(255)));
        send_idle_pct = 28;
        recv_stall_pct = 28;
        test_random_traffic(110);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_VERSION;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = '0;
        in_ch.end_of_packet = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        mismatch_count = 0;
        reg_val[REG_VERSION] = 8'd1;
        reg_val[REG_WAKE] = 8'd0;
        reg_val[REG_FRAME] = 8'd1;
        reg_val[REG_STATUS] = 8'd2;
        reg_val[REG_SLEEPING] = 8'd3;
        reg_val[REG_SET] = 8'd4;
        reg_val[REG_ACK] = 8'd5;
        clear_packet_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_short_packets();
        test_good_config_set();
        test_back_pressure();
        test_random_traffic(110);
        test_long_packet();
        test_extreme_codes();
        test_duplicate_codes();
        test_random_codes();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- telemetry_packet_deframer.f -----
sv/tpd_pkg.sv
sv/tpd_if.sv
sv/tpd_crc_step.sv
sv/tpd_field_map.sv
sv/telemetry_packet_deframer.sv
sim/testbench.sv
